// ===== sv/symmetric_conv3x3_rgb_defines.svh =====
// Assertion macros shared by the convolution block.
`ifndef SYMMETRIC_CONV3X3_RGB_DEFINES_SVH
`define SYMMETRIC_CONV3X3_RGB_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SC3_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sc3 assertion failed");

// Next-cycle implication, disabled in reset.
`define SC3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sc3 assertion failed");

`endif

// ===== sv/sc3_pkg.sv =====
// Package: widths, register map, shared types of the 3x3 convolution block.
package sc3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int HEIGHT_MAX = 4096;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int IW_W       = 12;
  localparam int IH_W       = 13;
  localparam int WGT_W      = 11;
  localparam int SCL_W      = 16;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;

  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_CORNER_WEIGHT = 3'd2;
  localparam logic [2:0] REG_EDGE_WEIGHT   = 3'd3;
  localparam logic [2:0] REG_CENTRE_WEIGHT = 3'd4;
  localparam logic [2:0] REG_SCALE_FACTOR  = 3'd5;

  typedef struct packed {
    logic        [IW_W-1:0]  image_width;
    logic        [IH_W-1:0]  image_height;
    logic signed [WGT_W-1:0] corner_weight;
    logic signed [WGT_W-1:0] edge_weight;
    logic signed [WGT_W-1:0] centre_weight;
    logic signed [SCL_W-1:0] scale_factor;
  } sc3_cfg_t;

  typedef struct packed {
    logic load;
    logic upd;
  } sc3_win_ctl_t;

  typedef logic [8:0][RGB_W-1:0] sc3_win_t;
  typedef logic [8:0][PIX_W-1:0] sc3_chan_win_t;

endpackage

// ===== sv/sc3_if.sv =====
// Valid/ready channel interfaces for pixel requests and filtered results.
interface sc3_in_if;
  logic                      valid;
  logic                      ready;
  logic [sc3_pkg::PIX_W-1:0] red_in;
  logic [sc3_pkg::PIX_W-1:0] green_in;
  logic [sc3_pkg::PIX_W-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface sc3_out_if;
  logic                      valid;
  logic                      ready;
  logic [sc3_pkg::PIX_W-1:0] red_out;
  logic [sc3_pkg::PIX_W-1:0] green_out;
  logic [sc3_pkg::PIX_W-1:0] blue_out;
  logic [sc3_pkg::COL_W-1:0] column;
  logic [sc3_pkg::ROW_W-1:0] row;
  logic                      frame_end;

  modport source (output valid, red_out, green_out, blue_out, column, row, frame_end,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, column, row, frame_end,
                  output ready);
endinterface

// ===== sv/sc3_cfg_regs.sv =====
// APB configuration registers of the convolution block.
module sc3_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sc3_pkg::APB_AW-1:0] paddr,
  input  logic [sc3_pkg::APB_DW-1:0] pwdata,
  output logic [sc3_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output sc3_pkg::sc3_cfg_t          cfg
);
  import sc3_pkg::*;

  sc3_cfg_t   cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[APB_AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width   <= IW_W'(640);
      cfg_r.image_height  <= IH_W'(480);
      cfg_r.corner_weight <= '0;
      cfg_r.edge_weight   <= '0;
      cfg_r.centre_weight <= '0;
      cfg_r.scale_factor  <= '0;
    end else if (wr) begin
      case (idx)
        REG_IMAGE_WIDTH:   cfg_r.image_width   <= pwdata[IW_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_r.image_height  <= pwdata[IH_W-1:0];
        REG_CORNER_WEIGHT: cfg_r.corner_weight <= pwdata[WGT_W-1:0];
        REG_EDGE_WEIGHT:   cfg_r.edge_weight   <= pwdata[WGT_W-1:0];
        REG_CENTRE_WEIGHT: cfg_r.centre_weight <= pwdata[WGT_W-1:0];
        REG_SCALE_FACTOR:  cfg_r.scale_factor  <= pwdata[SCL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:   prdata = APB_DW'(cfg_r.image_width);
      REG_IMAGE_HEIGHT:  prdata = APB_DW'(cfg_r.image_height);
      REG_CORNER_WEIGHT: prdata = APB_DW'($unsigned(cfg_r.corner_weight));
      REG_EDGE_WEIGHT:   prdata = APB_DW'($unsigned(cfg_r.edge_weight));
      REG_CENTRE_WEIGHT: prdata = APB_DW'($unsigned(cfg_r.centre_weight));
      REG_SCALE_FACTOR:  prdata = APB_DW'($unsigned(cfg_r.scale_factor));
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== sv/sc3_window.sv =====
// Two line stores and the 3x3 RGB window.
module sc3_window (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sc3_pkg::sc3_win_ctl_t      ctl,
  input  logic [sc3_pkg::ADDR_W-1:0] addr,
  input  logic [sc3_pkg::RGB_W-1:0]  px,
  output sc3_pkg::sc3_win_t          win
);
  import sc3_pkg::*;

  logic [RGB_W-1:0]  upper_mem [MAX_WIDTH];
  logic [RGB_W-1:0]  middle_mem [MAX_WIDTH];
  logic [RGB_W-1:0]  up_rd_r;
  logic [RGB_W-1:0]  mid_rd_r;
  logic [RGB_W-1:0]  px_r;
  logic [ADDR_W-1:0] addr_r;
  sc3_win_t          win_r;

  assign win = win_r;

  // read on request, write back the shifted column in the cycle after the read
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      up_rd_r <= upper_mem[addr];
    end
    if (ctl.upd) begin
      upper_mem[addr_r] <= mid_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mid_rd_r <= middle_mem[addr];
    end
    if (ctl.upd) begin
      middle_mem[addr_r] <= px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      px_r   <= px;
      addr_r <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctl.upd) begin
      for (int k = 0; k < 3; k++) begin
        win_r[3*k]   <= win_r[3*k+1];
        win_r[3*k+1] <= win_r[3*k+2];
      end
      win_r[2] <= up_rd_r;
      win_r[5] <= mid_rd_r;
      win_r[8] <= px_r;
    end
  end

endmodule

// ===== sv/sc3_lane.sv =====
// One color lane: weighted kernel sum, Q8.8 scale, clamp to 0..255.
module sc3_lane (
  input  logic                        clk,
  input  sc3_pkg::sc3_chan_win_t      win,
  input  sc3_pkg::sc3_cfg_t           cfg,
  output logic [sc3_pkg::PIX_W-1:0]   pix
);
  import sc3_pkg::*;

  localparam int SUM_W = PIX_W + 2;
  localparam int PC_W  = WGT_W + SUM_W + 1;
  localparam int PM_W  = WGT_W + PIX_W + 1;
  localparam int S_W   = 24;
  localparam int P_W   = S_W + SCL_W;

  logic        [SUM_W-1:0] corner_sum;
  logic        [SUM_W-1:0] edge_sum;
  logic signed [PC_W-1:0]  pc_r;
  logic signed [PC_W-1:0]  pe_r;
  logic signed [PM_W-1:0]  pm_r;
  logic signed [S_W-1:0]   s_r;
  logic signed [P_W-1:0]   p_r;

  assign corner_sum = SUM_W'(win[0]) + SUM_W'(win[2]) + SUM_W'(win[6]) + SUM_W'(win[8]);
  assign edge_sum   = SUM_W'(win[1]) + SUM_W'(win[3]) + SUM_W'(win[5]) + SUM_W'(win[7]);

  always_ff @(posedge clk) begin
    pc_r <= cfg.corner_weight * $signed({1'b0, corner_sum});
    pe_r <= cfg.edge_weight   * $signed({1'b0, edge_sum});
    pm_r <= cfg.centre_weight * $signed({1'b0, win[4]});
    s_r  <= S_W'(pc_r) + S_W'(pe_r) + S_W'(pm_r);
    p_r  <= s_r * cfg.scale_factor;
  end

  // negative products clamp to zero, so truncation toward zero needs no bias
  always_comb begin
    if (p_r[P_W-1]) begin
      pix = '0;
    end else if (|p_r[P_W-2:PIX_W+8]) begin
      pix = '1;
    end else begin
      pix = p_r[PIX_W+7:8];
    end
  end

endmodule

// ===== sv/symmetric_conv3x3_rgb.sv =====
// Top level: 3x3 symmetric-kernel convolution over an RGB raster stream.
// Pixel requests arrive on in_px in raster order, one RGB pixel per request.
// Each pixel whose 3x3 neighborhood is complete (row >= 2, column >= 2) yields
// one result on out_px for the pixel one row up and one column left, with its
// column, row and a frame_end flag on the last interior pixel of the frame.
// Border pixels give no result.
// A request passes through these steps: accept with line store read, window
// shift and write back, three lane stages (weight products, kernel sum, Q8.8
// scale), then the output load. The three color lanes run side by side; the
// output register merges them.
// A request is taken only once the one before it is in the output register
// or dropped as a border pixel. in_px.ready is high only between requests.
// The output register lets the next request enter while a result waits;
// a stalled receiver holds the block only when a new result is ready.
// Reset clears counters, window and config to defaults; line stores are
// filled by the first two rows of a frame. Configuration goes through the
// APB port while the block is idle: the user ensures this, the block does not.
module symmetric_conv3x3_rgb (
  input  logic                       clk,
  input  logic                       rst_n,
  sc3_in_if.sink                     in_px,
  sc3_out_if.source                  out_px,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sc3_pkg::APB_AW-1:0] paddr,
  input  logic [sc3_pkg::APB_DW-1:0] pwdata,
  output logic [sc3_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import sc3_pkg::*;
  `include "symmetric_conv3x3_rgb_defines.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_PIPE = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  sc3_cfg_t      cfg;
  sc3_win_ctl_t  win_ctl;
  sc3_win_t      win;
  sc3_chan_win_t chan_win [3];
  logic [PIX_W-1:0] lane_pix [3];

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             has_res_r;
  logic [COL_W-1:0] res_col_r;
  logic [ROW_W-1:0] res_row_r;
  logic             res_fe_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic             out_fe_r;

  logic             accept;
  logic             out_load;
  logic [IW_W-1:0]  wdt_eff;
  logic [IH_W-1:0]  hgt_eff;
  logic [IW_W-1:0]  col_inc;
  logic [IH_W-1:0]  row_inc;
  logic             frame_end;

  sc3_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign win_ctl.load = accept;
  assign win_ctl.upd  = (state_r == ST_UPD);

  sc3_window u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (win_ctl),
    .addr  (col_r[ADDR_W-1:0]),
    .px    ({in_px.red_in, in_px.green_in, in_px.blue_in}),
    .win   (win)
  );

  for (genvar c = 0; c < 3; c++) begin : g_lane
    always_comb begin
      for (int k = 0; k < 9; k++) begin
        chan_win[c][k] = win[k][RGB_W-1-PIX_W*c -: PIX_W];
      end
    end

    sc3_lane u_lane (
      .clk (clk),
      .win (chan_win[c]),
      .cfg (cfg),
      .pix (lane_pix[c])
    );
  end

  assign in_px.ready = (state_r == ST_IDLE);
  assign accept      = in_px.valid && in_px.ready;

  // effective frame size
  always_comb begin
    if (cfg.image_width < IW_W'(3)) begin
      wdt_eff = IW_W'(3);
    end else if (cfg.image_width > IW_W'(MAX_WIDTH)) begin
      wdt_eff = IW_W'(MAX_WIDTH);
    end else begin
      wdt_eff = cfg.image_width;
    end
    if (cfg.image_height < IH_W'(3)) begin
      hgt_eff = IH_W'(3);
    end else if (cfg.image_height > IH_W'(HEIGHT_MAX)) begin
      hgt_eff = IH_W'(HEIGHT_MAX);
    end else begin
      hgt_eff = cfg.image_height;
    end
  end

  assign col_inc   = IW_W'(col_r) + IW_W'(1);
  assign row_inc   = IH_W'(row_r) + IH_W'(1);
  assign frame_end = (IH_W'(row_r) == hgt_eff - IH_W'(1)) &&
                     (IW_W'(col_r) == wdt_eff - IW_W'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= wdt_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= hgt_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  assign out_load = (state_r == ST_OUT) && has_res_r && (!out_valid_r || out_px.ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_PIPE;
        cnt_nxt   = '0;
      end
      ST_PIPE: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!has_res_r || out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      has_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (accept) begin
        has_res_r <= (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_px.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_col_r <= col_r - COL_W'(1);
      res_row_r <= row_r - ROW_W'(1);
      res_fe_r  <= frame_end;
    end
    if (out_load) begin
      out_red_r   <= lane_pix[0];
      out_green_r <= lane_pix[1];
      out_blue_r  <= lane_pix[2];
      out_col_r   <= res_col_r;
      out_row_r   <= res_row_r;
      out_fe_r    <= res_fe_r;
    end
  end

  assign out_px.valid     = out_valid_r;
  assign out_px.red_out   = out_red_r;
  assign out_px.green_out = out_green_r;
  assign out_px.blue_out  = out_blue_r;
  assign out_px.column    = out_col_r;
  assign out_px.row       = out_row_r;
  assign out_px.frame_end = out_fe_r;

  `SC3_ASSERT_NEXT(a_accept_to_upd, clk, rst_n, accept, state_r == ST_UPD)
  `SC3_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !in_px.ready)
  `SC3_ASSERT_NEXT(a_result_loaded, clk, rst_n,
    (state_r == ST_OUT) && has_res_r && (!out_valid_r || out_px.ready),
    out_valid_r && (state_r == ST_IDLE))
  `SC3_ASSERT_NOW(a_pipe_count, clk, rst_n, state_r == ST_PIPE, cnt_r != 2'd3)

endmodule

// ===== verif/conv_tb_pkg.sv =====
// Scoreboard package: 3x3 window predictor and queue of expected filtered pixels.
`timescale 1ns / 100ps
package conv_tb_pkg;
  import sc3_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             frame_end;
  } filt_px_t;

  class conv3x3_scoreboard;
    sc3_cfg_t         cfg;
    logic [RGB_W-1:0] upper_line [MAX_WIDTH];
    logic [RGB_W-1:0] middle_line [MAX_WIDTH];
    logic [RGB_W-1:0] window [9];
    byte              visits [MAX_WIDTH];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    filt_px_t         expected_q [$];
    int               errors;

    function new();
      cfg.image_width   = 12'd640;
      cfg.image_height  = 13'd480;
      cfg.corner_weight = '0;
      cfg.edge_weight   = '0;
      cfg.centre_weight = '0;
      cfg.scale_factor  = '0;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
        visits[i]      = 0;
      end
      foreach (window[i]) window[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors  = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH:   cfg.image_width   = value[IW_W-1:0];
        REG_IMAGE_HEIGHT:  cfg.image_height  = value[IH_W-1:0];
        REG_CORNER_WEIGHT: cfg.corner_weight = value[WGT_W-1:0];
        REG_EDGE_WEIGHT:   cfg.edge_weight   = value[WGT_W-1:0];
        REG_CENTRE_WEIGHT: cfg.centre_weight = value[WGT_W-1:0];
        REG_SCALE_FACTOR:  cfg.scale_factor  = value[SCL_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = cfg.image_width;
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
    endfunction

    function int unsigned eff_height();
      int unsigned h;
      h = cfg.image_height;
      if (h < 3) h = 3;
      if (h > HEIGHT_MAX) h = HEIGHT_MAX;
      return h;
    endfunction

    // Columns below this value hold defined data in both line stores.
    function int covered_width();
      for (int i = 0; i < MAX_WIDTH; i++)
        if (visits[i] < 2) return i;
      return MAX_WIDTH;
    endfunction

    function bit at_frame_start();
      return (col_cnt == 0) && (row_cnt == 0);
    endfunction

    function longint lane(logic [RGB_W-1:0] px, int sh);
      return longint'((px >> sh) & 24'hFF);
    endfunction

    function logic [PIX_W-1:0] filter_lane(int sh);
      longint corners, edges, centre, acc, scaled;
      corners = lane(window[0], sh) + lane(window[2], sh) + lane(window[6], sh)
              + lane(window[8], sh);
      edges   = lane(window[1], sh) + lane(window[3], sh) + lane(window[5], sh)
              + lane(window[7], sh);
      centre  = lane(window[4], sh);
      acc = longint'($signed(cfg.corner_weight)) * corners
          + longint'($signed(cfg.edge_weight)) * edges
          + longint'($signed(cfg.centre_weight)) * centre;
      scaled = acc * longint'($signed(cfg.scale_factor)) / 256;
      if (scaled < 0) return '0;
      if (scaled > 255) return 8'hFF;
      return scaled[PIX_W-1:0];
    endfunction

    function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
      logic [RGB_W-1:0] px, up, mid;
      int unsigned      wdt, hgt, k;
      filt_px_t         res;
      wdt = eff_width();
      hgt = eff_height();
      px  = {r, g, b};
      k   = col_cnt % MAX_WIDTH;
      up  = upper_line[k];
      mid = middle_line[k];
      upper_line[k]  = mid;
      middle_line[k] = px;
      if (visits[k] < 2) visits[k]++;
      for (int i = 0; i < 3; i++) begin
        window[3*i]   = window[3*i+1];
        window[3*i+1] = window[3*i+2];
      end
      window[2] = up;
      window[5] = mid;
      window[8] = px;
      if (row_cnt >= 2 && col_cnt >= 2) begin
        res.red       = filter_lane(16);
        res.green     = filter_lane(8);
        res.blue      = filter_lane(0);
        res.column    = COL_W'(col_cnt - 1);
        res.row       = ROW_W'(row_cnt - 1);
        res.frame_end = (row_cnt == hgt - 1) && (col_cnt == wdt - 1);
        expected_q.push_back(res);
      end
      col_cnt++;
      if (col_cnt >= wdt) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= hgt) row_cnt = 0;
      end
    endfunction

    function void field_mismatch(string name, filt_px_t want, logic [15:0] exp_v,
                                 logic [15:0] got_v);
      $display("%0t: %s at col %0d row %0d expected %0d actual %0d",
               $time, name, want.column, want.row, exp_v, got_v);
      errors++;
    endfunction

    function void check_filtered(filt_px_t got);
      filt_px_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: filtered pixel with none expected, col %0d row %0d",
                 $time, got.column, got.row);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.red !== want.red)
        field_mismatch("red_out", want, 16'(want.red), 16'(got.red));
      if (got.green !== want.green)
        field_mismatch("green_out", want, 16'(want.green), 16'(got.green));
      if (got.blue !== want.blue)
        field_mismatch("blue_out", want, 16'(want.blue), 16'(got.blue));
      if (got.column !== want.column)
        field_mismatch("column", want, 16'(want.column), 16'(got.column));
      if (got.row !== want.row)
        field_mismatch("row", want, 16'(want.row), 16'(got.row));
      if (got.frame_end !== want.frame_end)
        field_mismatch("frame_end", want, 16'(want.frame_end), 16'(got.frame_end));
    endfunction
  endclass

endpackage

// ===== verif/tb.sv =====
// Testbench top: drives pixel requests and APB writes and reads, checks register reset values and filtered pixels.
`timescale 1ns / 100ps
module tb;
  import sc3_pkg::*;
  import conv_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 1650;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sc3_in_if  in_px ();
  sc3_out_if out_px ();

  conv3x3_scoreboard sb = new();
  bit                idle_on = 1'b1;
  bit                hold_req = 1'b0;
  int                pixels_sent = 0;
  int                cycles = 0;

  symmetric_conv3x3_rgb i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_px   (in_px),
    .out_px  (out_px),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("symmetric_conv3x3_rgb verification failed");
      $finish;
    end
  end

  // result receiver
  initial begin
    int hold_left;
    hold_left = 0;
    out_px.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_px.valid && out_px.ready)
        sb.check_filtered({out_px.red_out, out_px.green_out, out_px.blue_out,
                           out_px.column, out_px.row, out_px.frame_end});
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_px.ready <= 1'b0;
      end else begin
        out_px.ready <= !(idle_on && $urandom_range(99) < 12);
      end
    end
  end

  function automatic logic [PIX_W-1:0] rand_level(int style);
    case (style)
      0: return 8'($urandom_range(255));
      1: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return $urandom_range(1) ? 8'($urandom_range(7)) : 8'(248 + $urandom_range(7));
    endcase
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(5))
      0: return -1024;
      1: return 1023;
      2: return $urandom_range(8);
      3: return int'($urandom_range(2047)) - 1024;
      default: return int'($urandom_range(4)) - 2;
    endcase
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read_check(logic [2:0] idx, logic [APB_DW-1:0] want, int width);
    logic [APB_DW-1:0] mask;
    mask = (32'd1 << width) - 1;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (want & mask)) begin
      $display("%0t: register %0d expected %h actual %h", $time, idx, want & mask,
               prdata & mask);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    if (idle_on)
      while ($urandom_range(99) < 12) begin
        in_px.valid <= 1'b0;
        @(posedge clk);
      end
    in_px.valid    <= 1'b1;
    in_px.red_in   <= r;
    in_px.green_in <= g;
    in_px.blue_in  <= b;
    do @(posedge clk); while (!in_px.ready);
    sb.note_pixel(r, g, b);
    pixels_sent++;
  endtask

  task automatic feed(int n, int style);
    repeat (n) send_pixel(rand_level(style), rand_level(style), rand_level(style));
  endtask

  task automatic feed_to_frame_start(int style);
    do send_pixel(rand_level(style), rand_level(style), rand_level(style));
    while (!sb.at_frame_start());
  endtask

  task automatic settle();
    in_px.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(int wd, int ht, int cw, int ew, int mw, int sf);
    settle();
    reg_write(REG_IMAGE_WIDTH, wd);
    reg_write(REG_IMAGE_HEIGHT, ht);
    reg_write(REG_CORNER_WEIGHT, cw);
    reg_write(REG_EDGE_WEIGHT, ew);
    reg_write(REG_CENTRE_WEIGHT, mw);
    reg_write(REG_SCALE_FACTOR, sf);
  endtask

  initial begin
    int base, wd, ht, sf, frame_len, style, phase, pick;
    rst_n          <= 1'b0;
    in_px.valid    <= 1'b0;
    in_px.red_in   <= '0;
    in_px.green_in <= '0;
    in_px.blue_in  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reg_read_check(REG_IMAGE_WIDTH, 640, IW_W);
    reg_read_check(REG_IMAGE_HEIGHT, 480, IH_W);
    reg_read_check(REG_CORNER_WEIGHT, 0, WGT_W);
    reg_read_check(REG_EDGE_WEIGHT, 0, WGT_W);
    reg_read_check(REG_CENTRE_WEIGHT, 0, WGT_W);
    reg_read_check(REG_SCALE_FACTOR, 0, SCL_W);

    // minimal 3x3 frames: positive overflow, negative clamp, width/height below 3,
    // small scale truncation
    reconfigure(3, 3, -1024, -1024, -1024, -32768);
    repeat (9) send_pixel(8'hFF, 8'hFF, 8'hFF);
    reconfigure(0, 0, 1023, -1024, 1023, 32767);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, 8'h00, (i % 2) ? 8'hFF : 8'h00);
    reconfigure(2, 1, 1, 2, 4, 1);
    feed(9, 0);

    // output held off while the sender keeps pushing
    reconfigure(4, 8, 1, 1, 1, 32);
    hold_req = 1'b1;
    feed(64, 0);

    base  = pixels_sent;
    phase = 0;
    while (pixels_sent - base < RANDOM_ITEMS) begin
      idle_on = (pixels_sent - base) >= 450;
      pick = $urandom_range(99);
      if (pick < 10) wd = $urandom_range(2);
      else if (pick < 20) wd = 3;
      else wd = $urandom_range(40, 4);
      if (!sb.at_frame_start() && wd > sb.covered_width()) wd = sb.covered_width();
      pick = $urandom_range(99);
      if (pick < 10) ht = $urandom_range(2);
      else if (pick < 16) ht = $urandom_range(8191, 4096);
      else ht = $urandom_range(10, 3);
      pick = $urandom_range(99);
      if (pick < 15) begin
        case ($urandom_range(3))
          0: sf = -32768;
          1: sf = 32767;
          2: sf = 0;
          default: sf = 1;
        endcase
      end else if (pick < 65) begin
        sf = $urandom_range(96, 8);
      end else begin
        sf = int'($urandom_range(65535)) - 32768;
      end
      reconfigure(wd, ht, pick_weight(), pick_weight(), pick_weight(), sf);
      style     = $urandom_range(2);
      frame_len = ((wd < 3) ? 3 : wd) * ((ht < 3) ? 3 : ht);
      if (ht > 10) begin
        feed($urandom_range(150, 20), style);
      end else begin
        feed($urandom_range(2 * frame_len, 1), style);
        if ($urandom_range(1)) feed_to_frame_start(style);
      end
      phase++;
    end

    // width above the line store size, then both sizes cut mid-frame
    idle_on = 1'b1;
    reconfigure(3, 3, 1, 2, 1, 20);
    feed_to_frame_start(0);
    idle_on = 1'b0;
    reconfigure(4095, 8191, 1, 2, 1, 20);
    feed(40, 0);
    idle_on = 1'b1;
    reconfigure(2, 5, 1, 2, 1, 20);
    feed_to_frame_start(0);

    settle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("symmetric_conv3x3_rgb verification clean");
    end else begin
      $display("symmetric_conv3x3_rgb verification failed");
    end
    $finish;
  end

endmodule
